// File: rtl/core/svsp_pkg.sv
`timescale 1ns / 1ps

package svsp_pkg;

   localparam int unsigned PULSE_W    = 12;
   localparam int unsigned ANGLE_W    = 8;
   localparam int unsigned INTERVAL_W = 10;
   localparam int unsigned DWELL_W    = 12;
   localparam int unsigned ELAPSED_W  = 13;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 12;

   localparam logic [ANGLE_W-1:0]   ANGLE_TOP     = 8'd180;
   localparam logic [ANGLE_W-1:0]   ANGLE_MID     = 8'd90;
   localparam logic [ANGLE_W-1:0]   ANGLE_LOW     = 8'd0;
   localparam logic [ELAPSED_W-1:0] ELAPSED_LIMIT = 13'd8191;

   // Division by 180 is done as a shift by two and a multiply by ceil(2^24 / 45).
   // The rounding error of the constant is small enough to be exact for 18-bit values.
   localparam int unsigned  PROD_W     = 20;
   localparam int unsigned  RECIP_SH   = 24;
   localparam logic [18:0]  RECIP_45   = 19'd372828;

   localparam logic [PULSE_W-1:0]    PULSE_MIN_RST      = 12'd150;
   localparam logic [PULSE_W-1:0]    PULSE_MAX_RST      = 12'd600;
   localparam logic [INTERVAL_W-1:0] STEP_INTERVAL_RST  = 10'd15;
   localparam logic [DWELL_W-1:0]    END_DWELL_RST      = 12'd500;
   localparam logic [DWELL_W-1:0]    CENTER_DWELL_RST   = 12'd1000;

   typedef enum logic [1:0] {
      PHASE_RISE   = 2'd0,
      PHASE_FALL   = 2'd1,
      PHASE_RETURN = 2'd2
   } phase_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PULSE_MIN     = 3'd0,
      CSR_PULSE_MAX     = 3'd1,
      CSR_STEP_INTERVAL = 3'd2,
      CSR_END_DWELL     = 3'd3,
      CSR_CENTER_DWELL  = 3'd4
   } csr_index_type;

endpackage

// File: rtl/core/servo_sweep_pulse_generator.sv
`timescale 1ns / 1ps
// A stepping request passes s1, s2, s3 and the output register before rsp_valid rises.
// Throughput: one request per cycle; the 4-stage response pipeline stalls only when it is
// full and rsp_ready is low.
// Reset (synchronous, active high) returns the angle to 90 degrees in the rising phase,
// clears the millisecond count and dwell, empties the pipeline and restores the registers.

module servo_sweep_pulse_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_tick,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [svsp_pkg::PULSE_W-1:0]       rsp_pulse_width,
   output logic [svsp_pkg::ANGLE_W-1:0]       rsp_angle,
   output logic [1:0]                         rsp_phase,
   input  logic                               csr_we,
   input  logic [svsp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [svsp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import svsp_pkg::*;

   // Configuration registers
   logic [PULSE_W-1:0]    pulse_min_ff;
   logic [PULSE_W-1:0]    pulse_max_ff;
   logic [INTERVAL_W-1:0] step_interval_ff;
   logic [DWELL_W-1:0]    end_dwell_ff;
   logic [DWELL_W-1:0]    center_dwell_ff;

   // Sweep state
   logic [ANGLE_W-1:0]    position_ff, position_in;
   phase_type             phase_ff, phase_in;
   logic [ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic [DWELL_W-1:0]    dwell_ff, dwell_in;

   // Response pipeline
   logic                  s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic [ANGLE_W-1:0]    s1_angle_ff, s2_angle_ff, s3_angle_ff, out_angle_ff;
   phase_type             s1_phase_ff, s2_phase_ff, s3_phase_ff, out_phase_ff;
   logic                  s2_neg_ff, s3_neg_ff;
   logic [PROD_W-1:0]     s2_prod_ff, s2_prod_in;
   logic [PULSE_W-1:0]    s3_quot_ff, s3_quot_in;
   logic [PULSE_W-1:0]    out_pulse_ff, out_pulse_in;

   logic                  adv_out, adv_s3, adv_s2, adv_s1;
   logic                  accept, step_hit;
   logic [ELAPSED_W-1:0]  elapsed_inc, threshold;
   logic                  span_neg;
   logic [PULSE_W-1:0]    span_mag;
   logic [36:0]           recip_prod;

   assign adv_out   = !out_valid_ff || rsp_ready;
   assign adv_s3    = !s3_valid_ff || adv_out;
   assign adv_s2    = !s2_valid_ff || adv_s3;
   assign adv_s1    = !s1_valid_ff || adv_s2;
   assign req_ready = adv_s1;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_min_ff     <= PULSE_MIN_RST;
         pulse_max_ff     <= PULSE_MAX_RST;
         step_interval_ff <= STEP_INTERVAL_RST;
         end_dwell_ff     <= END_DWELL_RST;
         center_dwell_ff  <= CENTER_DWELL_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PULSE_MIN:     pulse_min_ff     <= csr_wdata;
            CSR_PULSE_MAX:     pulse_max_ff     <= csr_wdata;
            CSR_STEP_INTERVAL: step_interval_ff <= csr_wdata[INTERVAL_W-1:0];
            CSR_END_DWELL:     end_dwell_ff     <= csr_wdata;
            CSR_CENTER_DWELL:  center_dwell_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Step decision and angle update for the accepted tick.
   always_comb begin
      elapsed_inc = (elapsed_ff < ELAPSED_LIMIT) ? elapsed_ff + 1'b1 : elapsed_ff;
      threshold   = ELAPSED_W'(step_interval_ff) + ELAPSED_W'(dwell_ff);
      step_hit    = req_tick && (elapsed_inc >= threshold);

      position_in = position_ff;
      phase_in    = phase_ff;
      elapsed_in  = elapsed_ff;
      dwell_in    = dwell_ff;

      if (accept && req_tick) begin
         if (!step_hit) begin
            elapsed_in = elapsed_inc;
         end else begin
            elapsed_in = '0;
            dwell_in   = '0;
            case (phase_ff)
               PHASE_RISE: begin
                  if (position_ff + 1'b1 >= ANGLE_TOP) begin
                     position_in = ANGLE_TOP;
                     phase_in    = PHASE_FALL;
                     dwell_in    = end_dwell_ff;
                  end else begin
                     position_in = position_ff + 1'b1;
                  end
               end
               PHASE_FALL: begin
                  if (position_ff <= 8'd1) begin
                     position_in = ANGLE_LOW;
                     phase_in    = PHASE_RETURN;
                     dwell_in    = end_dwell_ff;
                  end else begin
                     position_in = position_ff - 1'b1;
                  end
               end
               PHASE_RETURN: begin
                  if (position_ff + 1'b1 >= ANGLE_MID) begin
                     position_in = ANGLE_MID;
                     phase_in    = PHASE_RISE;
                     dwell_in    = center_dwell_ff;
                  end else begin
                     position_in = position_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= ANGLE_MID;
         phase_ff    <= PHASE_RISE;
         elapsed_ff  <= '0;
         dwell_ff    <= '0;
      end else begin
         position_ff <= position_in;
         phase_ff    <= phase_in;
         elapsed_ff  <= elapsed_in;
         dwell_ff    <= dwell_in;
      end
   end

   // Pulse scaling: |span| * angle, then divide by 180, then add or subtract from the minimum.
   always_comb begin
      span_neg     = pulse_max_ff < pulse_min_ff;
      span_mag     = span_neg ? pulse_min_ff - pulse_max_ff : pulse_max_ff - pulse_min_ff;
      s2_prod_in   = PROD_W'(s1_angle_ff) * PROD_W'(span_mag);
      recip_prod   = 37'(s2_prod_ff[PROD_W-1:2]) * 37'(RECIP_45);
      s3_quot_in   = recip_prod[RECIP_SH+PULSE_W-1:RECIP_SH];
      out_pulse_in = s3_neg_ff ? pulse_min_ff - s3_quot_ff : pulse_min_ff + s3_quot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv_s1)  s1_valid_ff  <= accept && step_hit;
         if (adv_s2)  s2_valid_ff  <= s1_valid_ff;
         if (adv_s3)  s3_valid_ff  <= s2_valid_ff;
         if (adv_out) out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_s1) begin
         s1_angle_ff <= position_in;
         s1_phase_ff <= phase_in;
      end
      if (adv_s2) begin
         s2_angle_ff <= s1_angle_ff;
         s2_phase_ff <= s1_phase_ff;
         s2_prod_ff  <= s2_prod_in;
         s2_neg_ff   <= span_neg;
      end
      if (adv_s3) begin
         s3_angle_ff <= s2_angle_ff;
         s3_phase_ff <= s2_phase_ff;
         s3_quot_ff  <= s3_quot_in;
         s3_neg_ff   <= s2_neg_ff;
      end
      if (adv_out) begin
         out_angle_ff <= s3_angle_ff;
         out_phase_ff <= s3_phase_ff;
         out_pulse_ff <= out_pulse_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pulse_width = out_pulse_ff;
   assign rsp_angle       = out_angle_ff;
   assign rsp_phase       = 2'(out_phase_ff);

endmodule

// File: rtl/core/svsp_checker.sv
`timescale 1ns / 1ps

module svsp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [svsp_pkg::PULSE_W-1:0]       rsp_pulse_width,
   input logic [svsp_pkg::ANGLE_W-1:0]       rsp_angle,
   input logic [1:0]                         rsp_phase
);
   import svsp_pkg::*;

   // A held response keeps its payload until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pulse_width)
                                 && $stable(rsp_angle) && $stable(rsp_phase))
      else $error("response changed while stalled");

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle <= ANGLE_TOP && rsp_phase != 2'd3)
      else $error("angle or phase out of range");

   // The top end point is reported only as the turn into the falling phase.
   a_top_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_angle == ANGLE_TOP |-> rsp_phase == 2'(PHASE_FALL))
      else $error("angle 180 outside the falling phase");

   // The bottom end point is reported only as the turn into the return phase.
   a_low_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_angle == ANGLE_LOW |-> rsp_phase == 2'(PHASE_RETURN))
      else $error("angle 0 outside the return phase");

endmodule

bind servo_sweep_pulse_generator svsp_checker u_svsp_checker (.*);
